>>> rtl/lpaik_pkg.sv
package lpaik_pkg;

  // Default build values
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DURATION_RESET   = 500;

  // Fixed datapath widths
  localparam int POS_W     = 19;   // point coordinate, signed
  localparam int ZW        = 34;   // CORDIC angle accumulator, Q30 radians
  localparam int IW        = 52;   // CORDIC operand width at the port
  localparam int CW        = 56;   // CORDIC internal x/y width
  localparam int MAW       = 36;   // shared multiplier operand A, signed
  localparam int MBW       = 25;   // shared multiplier operand B, signed
  localparam int PW        = MAW + MBW;
  localparam int NW        = 36;   // path divider dividend width
  localparam int DW        = 16;   // path divider divisor width
  localparam int TABLE_LEN = 24;

  localparam int K_BASE = 5730;
  localparam int K_ARM  = 11460;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t PI_Q30 = 34'sd3373259426;

  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543515,  34'sd16775850,  34'sd8388438,
    34'sd4194283,   34'sd2097150,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  typedef enum logic [1:0] {
    C_IDLE,
    C_NORM,
    C_ITER
  } cst_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADV,
    S_PMUL,
    S_PDIV_GO,
    S_PDIV_W,
    S_ANG_GO,
    S_ANG_W,
    S_ANG_MUL,
    S_ANG_FIN,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_SQSUM,
    S_CHK,
    S_RT1_GO,
    S_RT1_W,
    S_RT2_GO,
    S_RT2_W,
    S_SMUL,
    S_RT3_GO,
    S_RT3_W,
    S_DMUL,
    S_NMUL,
    S_NZ,
    S_EMIT
  } st_t;

endpackage

>>> rtl/lpaik_cordic.sv
module lpaik_cordic #(
  parameter int STEPS = lpaik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [lpaik_pkg::IW-1:0] y_in,
  input  logic signed [lpaik_pkg::IW-1:0] x_in,
  output logic                            done,
  output logic signed [lpaik_pkg::ZW-1:0] z_out
);
  import lpaik_pkg::*;

  localparam int N   = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
  localparam int IXW = $clog2(TABLE_LEN);
  localparam logic signed [CW-1:0] NORM_MIN = CW'(longint'(1) << 40);

  cst_t                   cst_r;
  logic signed [CW-1:0]   x_r, y_r;
  ang_t                   z_r;
  logic [IXW-1:0]         i_r;
  logic                   done_r;
  logic signed [CW-1:0]   ay, m, dx, dy;

  // Magnitude bound and shifted terms of the current step
  always_comb begin
    ay = (y_r < 0) ? -y_r : y_r;
    m  = (x_r > ay) ? x_r : ay;
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
  end

  // Fold into the right half plane, scale up, then rotate toward the x axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r  <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (cst_r)
        C_IDLE: begin
          if (start) begin
            if (x_in == '0 && y_in == '0) begin
              z_r    <= '0;
              done_r <= 1'b1;
            end else if (x_in < 0) begin
              z_r   <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
              x_r   <= -CW'(x_in);
              y_r   <= -CW'(y_in);
              cst_r <= C_NORM;
            end else begin
              z_r   <= '0;
              x_r   <= CW'(x_in);
              y_r   <= CW'(y_in);
              cst_r <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (m < NORM_MIN) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            i_r   <= '0;
            cst_r <= C_ITER;
          end
        end
        C_ITER: begin
          if (y_r > 0) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + ATAN_TAB[i_r];
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - ATAN_TAB[i_r];
          end
          if (i_r == IXW'(N - 1)) begin
            cst_r  <= C_IDLE;
            done_r <= 1'b1;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        default: cst_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

>>> rtl/lpaik_isqrt.sv
module lpaik_isqrt #(
  parameter int W = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   v_in,
  output logic           done,
  output logic [W/2-1:0] r_out
);

  logic [W-1:0] v_r, r_r, b_r, t;
  logic         busy_r, done_r;

  assign t = r_r + b_r;

  // One result bit per cycle, floor square root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= v_in;
        r_r    <= '0;
        b_r    <= W'(1) << (W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= t) begin
          v_r <= v_r - t;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r <= b_r >> 2;
        if (b_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign r_out = r_r[W/2-1:0];

endmodule

>>> rtl/lpaik_div.sv
module lpaik_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [lpaik_pkg::NW-1:0] num,
  input  logic [lpaik_pkg::DW-1:0] den,
  output logic                    done,
  output logic [lpaik_pkg::NW-1:0] quo
);
  import lpaik_pkg::*;

  localparam int CNW = $clog2(NW + 1);

  logic [DW:0]    rem_r, rs;
  logic [DW-1:0]  den_r;
  logic [NW-1:0]  q_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r, done_r, ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rs = {rem_r[DW-1:0], q_r[NW-1]};
    ge = (rs >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
        cnt_r  <= CNW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? (rs - {1'b0, den_r}) : rs;
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> rtl/linear_path_arm_inverse_kinematics.sv
// Straight-line path follower for a two-link arm. A transfer with in_tuser high latches a
// new goal and answers with the held angles. A tick transfer advances the path point and
// solves the base angle and, when the point is in reach, the shoulder and elbow angles.
// The work is done by the single CORDIC unit (normalize shifts plus CORDIC_STEPS
// rotations, capped at the table length; one run when out of reach and three otherwise),
// the bit-serial square root (three runs when in reach) and, while on the path, the
// serial divider run once per axis. The block takes no new item until the result is
// loaded into the output register; that register holds it while the next item enters.
module linear_path_arm_inverse_kinematics #(
  parameter int FRAC_BITS    = lpaik_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = lpaik_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // goal_x[18:0], goal_y[37:19], goal_z[56:38]
  input  logic        in_tuser,   // command: 0 tick, 1 set goal
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // base[15:0], shoulder[32:16], elbow[49:33],
                                  // arm_ok[50], at_goal[51], out_of_reach[52]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata   // duration_ticks
);
  import lpaik_pkg::*;

  localparam int LW = (2 * FRAC_BITS > 40) ? 2 * FRAC_BITS : 40;
  localparam int RW = LW / 2;
  localparam longint HOME_L  = ((longint'(5) << FRAC_BITS) + 50) / 100;
  localparam longint LEN_L   = ((longint'(16) << FRAC_BITS) + 50) / 100;
  localparam longint REACH_L = ((longint'(256) << (2 * FRAC_BITS)) + 5000) / 10000;
  localparam pos_t                  HOME  = POS_W'(HOME_L);
  localparam logic [LW-1:0]         REACH = LW'(REACH_L);
  localparam logic signed [MBW-1:0] LEN   = MBW'(LEN_L);
  localparam logic signed [PW-1:0]  HALF  = PW'(longint'(1) << 29);

  st_t                    st_r, st_nxt;
  pos_t                   cur_r [3];
  pos_t                   np_r [3];
  pos_t                   goal_r [3];
  pos_t                   start_r [3];
  logic [15:0]            tick_r, dur_r;
  logic                   goal_set_r;
  logic signed [15:0]     base_r;
  logic signed [16:0]     sh_r, el_r;
  logic [1:0]             ax_r, ang_r;
  logic                   oor_r, neg_r;
  logic [LW-1:0]          rsq_r, lsq_r;
  logic [RW-1:0]          ra_r, rb_r;
  logic signed [IW-1:0]   s_r, den_r, nz_r;
  logic signed [PW-1:0]   prod_r, rnd, pabs;
  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [POS_W:0]  diff, qs, nsum;
  logic                   path_on, at_goal, arm_ok;
  logic                   out_tvalid_r;
  logic [55:0]            out_data_r;

  logic                   cor_go, cor_done;
  logic signed [IW-1:0]   cor_y, cor_x;
  ang_t                   cor_z;
  logic                   sq_go, sq_done;
  logic [LW-1:0]          sq_v;
  logic [RW-1:0]          sq_res;
  logic                   dv_go, dv_done;
  logic [NW-1:0]          dv_quo;

  lpaik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_go), .y_in(cor_y), .x_in(cor_x),
    .done(cor_done), .z_out(cor_z)
  );

  lpaik_isqrt #(.W(LW)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go), .v_in(sq_v),
    .done(sq_done), .r_out(sq_res)
  );

  lpaik_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_go), .num(NW'(pabs)), .den(dur_r),
    .done(dv_done), .quo(dv_quo)
  );

  // Path arithmetic and flags
  always_comb begin
    path_on = goal_set_r && (tick_r < dur_r);
    diff    = (POS_W + 1)'(goal_r[ax_r]) - (POS_W + 1)'(start_r[ax_r]);
    pabs    = (prod_r < 0) ? -prod_r : prod_r;
    qs      = neg_r ? -$signed({1'b0, dv_quo[POS_W-1:0]})
                    : $signed({1'b0, dv_quo[POS_W-1:0]});
    nsum    = (POS_W + 1)'(start_r[ax_r]) + qs;
    rnd     = (prod_r + HALF) >>> 30;
    at_goal = (cur_r[0] == goal_r[0]) && (cur_r[1] == goal_r[1]) &&
              (cur_r[2] == goal_r[2]);
    arm_ok  = !((sh_r < -17'sd10000) || (el_r < -17'sd10000));
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      S_PMUL: begin
        mul_a = MAW'(diff);
        mul_b = MBW'($signed({1'b0, tick_r}));
      end
      S_SQX: begin
        mul_a = MAW'(np_r[0]);
        mul_b = MBW'(np_r[0]);
      end
      S_SQY: begin
        mul_a = MAW'(np_r[1]);
        mul_b = MBW'(np_r[1]);
      end
      S_SQZ: begin
        mul_a = MAW'(np_r[2]);
        mul_b = MBW'(np_r[2]);
      end
      S_SMUL: begin
        mul_a = MAW'(ra_r);
        mul_b = MBW'(rb_r);
      end
      S_DMUL: begin
        mul_a = MAW'(sq_res);
        mul_b = LEN;
      end
      S_NMUL: begin
        mul_a = MAW'(np_r[2]);
        mul_b = LEN;
      end
      S_ANG_MUL: begin
        mul_a = MAW'(cor_z);
        mul_b = (ang_r == 2'd0) ? MBW'(K_BASE) : MBW'(K_ARM);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Unit start pulses and operands
  always_comb begin
    cor_go = (st_r == S_ANG_GO);
    dv_go  = (st_r == S_PDIV_GO);
    sq_go  = (st_r == S_RT1_GO) || (st_r == S_RT2_GO) || (st_r == S_RT3_GO);
    case (st_r)
      S_RT1_GO: sq_v = lsq_r;
      S_RT2_GO: sq_v = REACH - lsq_r;
      default:  sq_v = rsq_r;
    endcase
    case (ang_r)
      2'd0: begin
        cor_y = IW'(np_r[1]);
        cor_x = IW'(np_r[0]);
      end
      2'd1: begin
        cor_y = nz_r + s_r;
        cor_x = den_r;
      end
      default: begin
        cor_y = nz_r - s_r;
        cor_x = den_r;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:    if (in_tvalid) st_nxt = in_tuser ? S_EMIT : S_ADV;
      S_ADV:     st_nxt = path_on ? S_PMUL : S_ANG_GO;
      S_PMUL:    st_nxt = S_PDIV_GO;
      S_PDIV_GO: st_nxt = S_PDIV_W;
      S_PDIV_W:  if (dv_done) st_nxt = (ax_r == 2'd2) ? S_ANG_GO : S_PMUL;
      S_ANG_GO:  st_nxt = S_ANG_W;
      S_ANG_W:   if (cor_done) st_nxt = S_ANG_MUL;
      S_ANG_MUL: st_nxt = S_ANG_FIN;
      S_ANG_FIN: begin
        case (ang_r)
          2'd0:    st_nxt = S_SQX;
          2'd1:    st_nxt = S_ANG_GO;
          default: st_nxt = S_EMIT;
        endcase
      end
      S_SQX:     st_nxt = S_SQY;
      S_SQY:     st_nxt = S_SQZ;
      S_SQZ:     st_nxt = S_SQSUM;
      S_SQSUM:   st_nxt = S_CHK;
      S_CHK:     st_nxt = (lsq_r > REACH) ? S_EMIT : S_RT1_GO;
      S_RT1_GO:  st_nxt = S_RT1_W;
      S_RT1_W:   if (sq_done) st_nxt = S_RT2_GO;
      S_RT2_GO:  st_nxt = S_RT2_W;
      S_RT2_W:   if (sq_done) st_nxt = S_SMUL;
      S_SMUL:    st_nxt = S_RT3_GO;
      S_RT3_GO:  st_nxt = S_RT3_W;
      S_RT3_W:   if (sq_done) st_nxt = S_DMUL;
      S_DMUL:    st_nxt = S_NMUL;
      S_NMUL:    st_nxt = S_NZ;
      S_NZ:      st_nxt = S_ANG_GO;
      S_EMIT:    if (!out_tvalid_r || out_tready) st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  // Product register of the shared multiplier
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Datapath and arm state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cur_r[i]   <= HOME;
        np_r[i]    <= HOME;
        goal_r[i]  <= HOME;
        start_r[i] <= HOME;
      end
      tick_r       <= '0;
      goal_set_r   <= 1'b0;
      dur_r        <= 16'(DURATION_RESET);
      base_r       <= '0;
      sh_r         <= '0;
      el_r         <= '0;
      oor_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      ax_r         <= '0;
      ang_r        <= '0;
    end else begin
      if (cfg_we) dur_r <= cfg_wdata;
      // Raise valid when a result is loaded, drop it once the transfer completes
      if (st_r == S_EMIT && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready)                                   out_tvalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            oor_r <= 1'b0;
            if (in_tuser) begin
              goal_r[0] <= in_tdata[18:0];
              goal_r[1] <= in_tdata[37:19];
              goal_r[2] <= in_tdata[56:38];
              for (int i = 0; i < 3; i++) start_r[i] <= cur_r[i];
              tick_r     <= '0;
              goal_set_r <= 1'b1;
            end
          end
        end
        S_ADV: begin
          for (int i = 0; i < 3; i++) cur_r[i] <= np_r[i];
          if (!path_on) begin
            for (int i = 0; i < 3; i++) np_r[i] <= goal_r[i];
          end
          ax_r  <= '0;
          ang_r <= '0;
        end
        S_PDIV_GO: neg_r <= (prod_r < 0);
        S_PDIV_W: begin
          if (dv_done) begin
            np_r[ax_r] <= nsum[POS_W-1:0];
            if (ax_r == 2'd2) tick_r <= tick_r + 1'b1;
            ax_r <= ax_r + 1'b1;
          end
        end
        S_ANG_FIN: begin
          case (ang_r)
            2'd0: begin
              if (rnd > PW'(18000))       base_r <= 16'sd18000;
              else if (rnd < -PW'(18000)) base_r <= -16'sd18000;
              else                        base_r <= rnd[15:0];
            end
            2'd1: begin
              sh_r  <= rnd[16:0];
              ang_r <= 2'd2;
            end
            default: el_r <= rnd[16:0];
          endcase
        end
        S_SQY:   rsq_r <= LW'(prod_r);
        S_SQZ:   rsq_r <= rsq_r + LW'(prod_r);
        S_SQSUM: lsq_r <= rsq_r + LW'(prod_r);
        S_CHK:   if (lsq_r > REACH) oor_r <= 1'b1;
        S_RT1_W: if (sq_done) ra_r <= sq_res;
        S_RT2_W: if (sq_done) rb_r <= sq_res;
        S_RT3_GO: s_r <= IW'(prod_r);
        S_NMUL:  den_r <= IW'(prod_r) + IW'(lsq_r);
        S_NZ: begin
          nz_r  <= IW'(prod_r);
          ang_r <= 2'd1;
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r <= {3'b000, oor_r, at_goal, arm_ok, el_r, sh_r, base_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Accepted item blocks further input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  // Tick count only runs once a goal exists
  a_tick_needs_goal: assert property (@(posedge clk) disable iff (!rst_n)
    !goal_set_r |-> (tick_r == '0))
    else $error("tick count moved without a goal");

  // Base angle stays within its saturation bounds
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd18000 &&
                    $signed(out_tdata[15:0]) >= -16'sd18000))
    else $error("base angle out of range");

endmodule
